@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the frame checker queue (rfc_fifo).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define RFC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Same-cycle implication.
`define RFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define RFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define RFC_ASSERT(lbl, expr)
`define RFC_ASSERT_IMP(lbl, ante, cons)
`define RFC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ design/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfc_pkg
// Types and constants of the response frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int unsigned FRAME_BYTES = 15;
  localparam int unsigned CNT_W       = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd16;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'h88;
  localparam logic [7:0] LEN_BYTE   = 8'(FRAME_BYTES);

  // Frame offsets
  localparam logic [CNT_W-1:0] OFS_START    = 5'd0;
  localparam logic [CNT_W-1:0] OFS_LEN      = 5'd1;
  localparam logic [CNT_W-1:0] OFS_VER      = 5'd2;
  localparam logic [CNT_W-1:0] OFS_CHECK    = 5'd3;
  localparam logic [CNT_W-1:0] OFS_ID_FIRST = 5'd4;
  localparam logic [CNT_W-1:0] OFS_ID_LAST  = 5'd11;
  localparam logic [CNT_W-1:0] OFS_RSP      = 5'd13;
  localparam logic [CNT_W-1:0] OFS_END      = 5'(FRAME_BYTES - 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_VALUE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MASK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAK_CODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_CODE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID        = 3'd5;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_START    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_END      = 3'd4,
    ST_RESPONSE = 3'd5,
    ST_CHECKSUM = 3'd6,
    ST_ID       = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  version_value;
    logic [7:0]  version_mask;
    logic [7:0]  ack_code;
    logic [7:0]  nak_code;
    logic [7:0]  err_code;
    logic [63:0] own_id;
  } cfg_t;

  // Per-byte error bits
  typedef struct packed {
    logic rsp;
    logic id;
    logic ver;
    logic len;
    logic start;
  } err_t;

  // Classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       absorb;    // offset within the frame
    logic       is_check;
    logic       is_rsp;
    logic       count_ok;  // last byte lands on the frame length
    err_t       err;
  } tok_t;

endpackage

@@ design/rfc_front.sv @@
// ----------------------------------------------------------------------------
// rfc_front
// Tracks byte offset and classifies each incoming byte against config.
// ----------------------------------------------------------------------------
module rfc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  rfc_pkg::cfg_t   cfg,
  input  logic            in_fire,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output rfc_pkg::tok_t   tok
);

  logic [rfc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [2:0]                id_sel;
  logic [7:0]                id_want;
  logic                      in_id;

  always_comb begin
    id_sel  = 3'(4'(rfc_pkg::OFS_ID_LAST) - count_r[3:0]);
    id_want = cfg.own_id[{id_sel, 3'b000} +: 8];
    in_id   = (count_r >= rfc_pkg::OFS_ID_FIRST) && (count_r <= rfc_pkg::OFS_ID_LAST);
  end

  always_comb begin
    tok.data      = in_byte;
    tok.last      = in_last;
    tok.absorb    = count_r < 5'(rfc_pkg::FRAME_BYTES);
    tok.is_check  = count_r == rfc_pkg::OFS_CHECK;
    tok.is_rsp    = count_r == rfc_pkg::OFS_RSP;
    tok.count_ok  = count_r == rfc_pkg::OFS_END;
    tok.err.start = (count_r == rfc_pkg::OFS_START) && (in_byte != rfc_pkg::START_BYTE);
    tok.err.len   = (count_r == rfc_pkg::OFS_LEN) && (in_byte != rfc_pkg::LEN_BYTE);
    tok.err.ver   = (count_r == rfc_pkg::OFS_VER) &&
                    ((in_byte & ~cfg.version_mask) != cfg.version_value);
    tok.err.id    = in_id && (in_byte != id_want);
    tok.err.rsp   = (count_r == rfc_pkg::OFS_RSP) && (in_byte != cfg.ack_code) &&
                    (in_byte != cfg.nak_code) && (in_byte != cfg.err_code);
  end

  // Saturating offset counter, cleared after the last byte
  always_comb begin
    count_nxt = count_r;
    if (in_fire) begin
      if (in_last) begin
        count_nxt = '0;
      end else if (count_r < rfc_pkg::COUNT_MAX) begin
        count_nxt = count_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ design/rfc_fifo.sv @@
// ----------------------------------------------------------------------------
// rfc_fifo
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rfc_pkg::tok_t  push_tok,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output rfc_pkg::tok_t  pop_tok
);

  rfc_pkg::tok_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = count_r == 2'd2;
  assign pop_valid = count_r != 2'd0;
  assign pop_tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `RFC_ASSERT(a_fifo_count_range, count_r <= 2'd2)
  `RFC_ASSERT_IMP(a_fifo_ptrs_track, count_r == 2'd0 || count_r == 2'd2, wr_ptr_r == rd_ptr_r)
  `RFC_ASSERT_NXT(a_fifo_push_grows, push && !pop, count_r == $past(count_r) + 2'd1)

endmodule

@@ design/rfc_back.sv @@
// ----------------------------------------------------------------------------
// rfc_back
// Accumulates checksum and sticky flags, resolves status on the last byte.
// ----------------------------------------------------------------------------
module rfc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_valid,
  input  rfc_pkg::tok_t   tok,
  output logic            tok_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output rfc_pkg::status_t out_status,
  output logic [7:0]      out_rsp
);

  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        chk_r, chk_nxt;
  logic [7:0]        rsp_r, rsp_nxt;
  rfc_pkg::err_t     flags_r, flags_nxt;
  logic              oval_r, oval_nxt;
  rfc_pkg::status_t  ostat_r, status;
  logic [7:0]        orsp_r;
  logic              slot_free;
  logic              emit;

  assign slot_free = !oval_r || out_ready;
  assign tok_pop   = tok_valid && (!tok.last || slot_free);
  assign emit      = tok_pop && tok.last;

  // Frame state as updated by the current byte
  always_comb begin
    sum_nxt   = sum_r;
    chk_nxt   = chk_r;
    rsp_nxt   = rsp_r;
    flags_nxt = flags_r;
    if (tok.absorb) begin
      if (tok.is_check) begin
        chk_nxt = tok.data;
      end else begin
        sum_nxt = sum_r + tok.data;
      end
      if (tok.is_rsp) begin
        rsp_nxt = tok.data;
      end
      flags_nxt = flags_r | tok.err;
    end
  end

  always_comb begin
    if (!tok.count_ok) begin
      status = rfc_pkg::ST_LENGTH;
    end else if (flags_nxt.start) begin
      status = rfc_pkg::ST_START;
    end else if (flags_nxt.len) begin
      status = rfc_pkg::ST_LENGTH;
    end else if (flags_nxt.ver) begin
      status = rfc_pkg::ST_VERSION;
    end else if (tok.data != rfc_pkg::END_BYTE) begin
      status = rfc_pkg::ST_END;
    end else if (flags_nxt.rsp) begin
      status = rfc_pkg::ST_RESPONSE;
    end else if (sum_nxt != chk_nxt) begin
      status = rfc_pkg::ST_CHECKSUM;
    end else if (flags_nxt.id) begin
      status = rfc_pkg::ST_ID;
    end else begin
      status = rfc_pkg::ST_OK;
    end
  end

  always_comb begin
    oval_nxt = oval_r;
    if (emit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      chk_r   <= '0;
      rsp_r   <= '0;
      flags_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
      if (emit) begin
        sum_r   <= '0;
        chk_r   <= '0;
        rsp_r   <= '0;
        flags_r <= '0;
      end else if (tok_pop) begin
        sum_r   <= sum_nxt;
        chk_r   <= chk_nxt;
        rsp_r   <= rsp_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ostat_r <= status;
      orsp_r  <= rsp_nxt;
    end
  end

  assign out_valid  = oval_r;
  assign out_status = ostat_r;
  assign out_rsp    = orsp_r;

endmodule

@@ design/response_frame_checker_core.sv @@
// ----------------------------------------------------------------------------
// response_frame_checker_core
// Streaming checker for fixed 15-byte response frames, one status per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per transaction in in_tdata, in_tlast on the final
//           byte. A transaction completes when in_tvalid and in_tready are high.
//   out_* : one status transaction per frame, issued for the in_tlast byte.
//           out_tdata[2:0] is the status code, out_tdata[10:3] the response
//           value byte captured at frame offset 13.
//   cfg_* : register writes (index, data); cfg_ready is always high. Write
//           only while no frame is in flight.
// Result path: the last byte is registered in the queue, then resolved into the
//   output register that drives out_tvalid; a held status can delay it.
// Throughput: one byte per cycle unless the status output stalls, set by the front classifier and the back
//   accumulator, each taking one byte per cycle; a two-entry queue sits
//   between them.
// Stalls: when out_tready is low the back end holds the finished status and
//   keeps absorbing bytes of the next frame until its last byte; the queue
//   then fills and in_tready drops.
// Reset: rst_n low for one clock clears the counter, queue, accumulators and
//   output valid, and restores register defaults.
// ----------------------------------------------------------------------------
module response_frame_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] status, [10:3] response_value, rest 0
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  rfc_pkg::cfg_t    cfg_r;
  rfc_pkg::tok_t    front_tok;
  rfc_pkg::tok_t    back_tok;
  rfc_pkg::status_t status;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             in_fire;
  logic [7:0]       rsp_value;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.version_value <= 8'd1;
      cfg_r.version_mask  <= 8'h40;
      cfg_r.ack_code      <= 8'd0;
      cfg_r.nak_code      <= 8'd1;
      cfg_r.err_code      <= 8'd2;
      cfg_r.own_id        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rfc_pkg::CFG_VERSION_VALUE: cfg_r.version_value <= cfg_data[7:0];
        rfc_pkg::CFG_VERSION_MASK:  cfg_r.version_mask  <= cfg_data[7:0];
        rfc_pkg::CFG_ACK_CODE:      cfg_r.ack_code      <= cfg_data[7:0];
        rfc_pkg::CFG_NAK_CODE:      cfg_r.nak_code      <= cfg_data[7:0];
        rfc_pkg::CFG_ERR_CODE:      cfg_r.err_code      <= cfg_data[7:0];
        rfc_pkg::CFG_OWN_ID:        cfg_r.own_id        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: offset tracking and per-byte checks
  rfc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .tok     (front_tok)
  );

  // Decoupling queue
  rfc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_tok  (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_tok   (back_tok)
  );

  // Back: checksum, sticky flags, status resolution and output register
  rfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (q_valid),
    .tok        (back_tok),
    .tok_pop    (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_rsp    (rsp_value)
  );

  assign out_tdata = {5'd0, rsp_value, status};

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for response_frame_checker_core. Frames are queued per
// register setting and streamed one byte per transaction with random bursts
// and gaps. A cycle-free predictor judges every accepted byte and keeps the
// status it expects per frame. The monitor checks each status transaction
// against the oldest expected status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction at all
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 45;    // minimum random bytes per register setting
  localparam int BUF_BYTES     = 25;

  // Fault injected into an otherwise well-formed frame
  typedef enum int {
    FAULT_NONE, FAULT_START, FAULT_LEN, FAULT_VER, FAULT_END,
    FAULT_RSP, FAULT_SUM, FAULT_ID, FAULT_ANY
  } fault_t;

  // Receiver stall patterns
  typedef enum int {RX_OPEN, RX_CHOPPY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_item_t;

  typedef struct {
    rfc_pkg::status_t status;
    logic [7:0]       rsp;
  } status_exp_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = rfc_pkg::CFG_VERSION_VALUE;
  logic [63:0] cfg_data = 64'h0;

  // Stimulus and expectation stores
  frame_item_t byte_queue[$];
  status_exp_t status_due[$];
  logic [7:0]  frame_buf[BUF_BYTES];
  frame_item_t next_item;

  // Predictor copy of registers and per-frame state
  rfc_pkg::cfg_t cur_cfg;
  logic [4:0]    byte_count;
  logic [7:0]    running_sum;
  logic [7:0]    check_byte;
  logic [7:0]    captured_rsp;
  rfc_pkg::err_t frame_err;

  // Bookkeeping
  int          bytes_queued = 0;
  int          bytes_accepted = 0;
  int          frames_queued = 0;
  int          settings_used = 0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          status_seen[8];
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_tick = 0;
  rx_mode_t    rx_mode = RX_OPEN;

  response_frame_checker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void clear_frame_state();
    byte_count   = '0;
    running_sum  = '0;
    check_byte   = '0;
    captured_rsp = '0;
    frame_err    = '0;
  endfunction

  // Judge one accepted byte; on the last byte of a frame queue its status.
  function automatic void judge_frame_byte(input logic [7:0] b, input logic last);
    logic [4:0]       ofs;
    logic [7:0]       want;
    rfc_pkg::status_t st;
    ofs = byte_count;
    if (ofs < rfc_pkg::FRAME_BYTES) begin
      // checksum byte is held apart, every other byte feeds the sum
      if (ofs == rfc_pkg::OFS_CHECK) check_byte = b;
      else running_sum = running_sum + b;
      if (ofs == rfc_pkg::OFS_START && b != rfc_pkg::START_BYTE) frame_err.start = 1'b1;
      if (ofs == rfc_pkg::OFS_LEN && b != rfc_pkg::LEN_BYTE) frame_err.len = 1'b1;
      if (ofs == rfc_pkg::OFS_VER &&
          (b & ~cur_cfg.version_mask) != cur_cfg.version_value)
        frame_err.ver = 1'b1;
      if (ofs >= rfc_pkg::OFS_ID_FIRST && ofs <= rfc_pkg::OFS_ID_LAST) begin
        // id arrives most significant byte first
        want = 8'(cur_cfg.own_id >> (8 * int'(rfc_pkg::OFS_ID_LAST - ofs)));
        if (b != want) frame_err.id = 1'b1;
      end
      if (ofs == rfc_pkg::OFS_RSP) begin
        captured_rsp = b;
        if (b != cur_cfg.ack_code && b != cur_cfg.nak_code && b != cur_cfg.err_code)
          frame_err.rsp = 1'b1;
      end
    end
    if (byte_count < rfc_pkg::COUNT_MAX) byte_count = byte_count + 5'd1;
    if (last) begin
      // first failing check wins
      if (byte_count != 5'(rfc_pkg::FRAME_BYTES)) st = rfc_pkg::ST_LENGTH;
      else if (frame_err.start)                  st = rfc_pkg::ST_START;
      else if (frame_err.len)                    st = rfc_pkg::ST_LENGTH;
      else if (frame_err.ver)                    st = rfc_pkg::ST_VERSION;
      else if (b != rfc_pkg::END_BYTE)           st = rfc_pkg::ST_END;
      else if (frame_err.rsp)                    st = rfc_pkg::ST_RESPONSE;
      else if (running_sum != check_byte)        st = rfc_pkg::ST_CHECKSUM;
      else if (frame_err.id)                     st = rfc_pkg::ST_ID;
      else                                       st = rfc_pkg::ST_OK;
      status_due.push_back('{st, captured_rsp});
      clear_frame_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Frame generation
  // --------------------------------------------------------------------------
  // Fill frame_buf[0..14] with a frame built from the current registers, then
  // spoil it as asked. The checksum is fixed up after the other faults so it
  // matches unless FAULT_SUM is asked.
  function automatic void build_frame(input fault_t fault);
    logic [7:0] sum;
    int         bitpos;
    frame_buf[rfc_pkg::OFS_START] = rfc_pkg::START_BYTE;
    frame_buf[rfc_pkg::OFS_LEN]   = rfc_pkg::LEN_BYTE;
    frame_buf[rfc_pkg::OFS_VER]   = (cur_cfg.version_value & ~cur_cfg.version_mask) |
                                    (8'($urandom) & cur_cfg.version_mask);
    for (int i = 0; i < 8; i++)
      frame_buf[rfc_pkg::OFS_ID_FIRST + i] = cur_cfg.own_id[8*(7-i) +: 8];
    frame_buf[12] = 8'($urandom);  // session, not checked
    case ($urandom_range(0, 2))
      0: frame_buf[rfc_pkg::OFS_RSP] = cur_cfg.ack_code;
      1: frame_buf[rfc_pkg::OFS_RSP] = cur_cfg.nak_code;
      default: frame_buf[rfc_pkg::OFS_RSP] = cur_cfg.err_code;
    endcase
    frame_buf[rfc_pkg::OFS_END] = rfc_pkg::END_BYTE;
    case (fault)
      FAULT_START: begin
        do frame_buf[rfc_pkg::OFS_START] = 8'($urandom);
        while (frame_buf[rfc_pkg::OFS_START] == rfc_pkg::START_BYTE);
      end
      FAULT_LEN: begin
        do frame_buf[rfc_pkg::OFS_LEN] = 8'($urandom);
        while (frame_buf[rfc_pkg::OFS_LEN] == rfc_pkg::LEN_BYTE);
      end
      FAULT_VER: begin
        // flip a compared bit; with everything masked there is none
        if (cur_cfg.version_mask != 8'hFF) begin
          do bitpos = $urandom_range(0, 7); while (cur_cfg.version_mask[bitpos]);
          frame_buf[rfc_pkg::OFS_VER][bitpos] = ~frame_buf[rfc_pkg::OFS_VER][bitpos];
        end
      end
      FAULT_END: begin
        do frame_buf[rfc_pkg::OFS_END] = 8'($urandom);
        while (frame_buf[rfc_pkg::OFS_END] == rfc_pkg::END_BYTE);
      end
      FAULT_RSP: frame_buf[rfc_pkg::OFS_RSP] = 8'($urandom);
      FAULT_ID:  frame_buf[$urandom_range(4, 11)] ^= 8'(1 << $urandom_range(0, 7));
      FAULT_ANY: frame_buf[$urandom_range(0, 14)] = 8'($urandom);
      default: ;
    endcase
    sum = '0;
    for (int i = 0; i < rfc_pkg::FRAME_BYTES; i++)
      if (i != rfc_pkg::OFS_CHECK) sum = sum + frame_buf[i];
    frame_buf[rfc_pkg::OFS_CHECK] = sum;
    if (fault == FAULT_SUM) frame_buf[rfc_pkg::OFS_CHECK] ^= 8'($urandom_range(1, 255));
  endfunction

  // Push frame_buf[0..len-1] for the driver, tlast on the final byte.
  function automatic void queue_frame(input int len);
    for (int i = 0; i < len; i++)
      byte_queue.push_back('{frame_buf[i], i == len - 1});
    bytes_queued  += len;
    frames_queued += 1;
  endfunction

  // Mostly well-formed frames with at most one fault, the rest broken lengths
  // and noise. Returns the number of bytes queued.
  function automatic int queue_random_frame();
    int len;
    int pick;
    pick = $urandom_range(0, 9);
    len  = rfc_pkg::FRAME_BYTES;
    if (pick <= 2) begin
      build_frame(FAULT_NONE);
    end else if (pick <= 6) begin
      build_frame(fault_t'($urandom_range(FAULT_START, FAULT_ANY)));
    end else if (pick == 7) begin
      build_frame(FAULT_NONE);          // truncated
      len = $urandom_range(1, 14);
    end else if (pick == 8) begin
      build_frame(FAULT_NONE);          // overrun past the end byte
      len = $urandom_range(16, BUF_BYTES);
      for (int i = rfc_pkg::FRAME_BYTES; i < len; i++) frame_buf[i] = 8'($urandom);
    end else begin
      len = $urandom_range(1, 20);      // noise
      for (int i = 0; i < len; i++) frame_buf[i] = 8'($urandom);
      if ($urandom_range(0, 1)) frame_buf[rfc_pkg::OFS_START] = rfc_pkg::START_BYTE;
    end
    queue_frame(len);
    return len;
  endfunction

  // --------------------------------------------------------------------------
  // Register writes and phase control
  // --------------------------------------------------------------------------
  // Call at a clock edge; leaves cfg_valid high for back-to-back writes.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rfc_pkg::CFG_VERSION_VALUE: cur_cfg.version_value = val[7:0];
      rfc_pkg::CFG_VERSION_MASK:  cur_cfg.version_mask  = val[7:0];
      rfc_pkg::CFG_ACK_CODE:      cur_cfg.ack_code      = val[7:0];
      rfc_pkg::CFG_NAK_CODE:      cur_cfg.nak_code      = val[7:0];
      rfc_pkg::CFG_ERR_CODE:      cur_cfg.err_code      = val[7:0];
      rfc_pkg::CFG_OWN_ID:        cur_cfg.own_id        = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] ver, input logic [7:0] mask,
                               input logic [7:0] ack, input logic [7:0] nak,
                               input logic [7:0] err, input logic [63:0] id);
    write_reg(rfc_pkg::CFG_VERSION_VALUE, {56'h0, ver});
    write_reg(rfc_pkg::CFG_VERSION_MASK,  {56'h0, mask});
    write_reg(rfc_pkg::CFG_ACK_CODE,      {56'h0, ack});
    write_reg(rfc_pkg::CFG_NAK_CODE,      {56'h0, nak});
    write_reg(rfc_pkg::CFG_ERR_CODE,      {56'h0, err});
    write_reg(rfc_pkg::CFG_OWN_ID,        id);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Wait until every queued byte is taken and every status is back, then let
  // the pipeline empty before touching registers.
  task automatic drain_and_settle();
    while (bytes_accepted != bytes_queued || status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_bytes;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    // register defaults after reset
    cur_cfg = '{version_value: 8'h01, version_mask: 8'h40, ack_code: 8'h00,
                nak_code: 8'h01, err_code: 8'h02, own_id: 64'h0};
    clear_frame_state();
    settings_used = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lone last byte, a clean frame, a frame one byte short
    // (response byte already captured) and one a byte too long.
    rx_mode <= RX_CHOPPY;
    frame_buf[0] = 8'hFF;
    queue_frame(1);
    build_frame(FAULT_NONE);
    queue_frame(rfc_pkg::FRAME_BYTES);
    build_frame(FAULT_NONE);
    queue_frame(rfc_pkg::FRAME_BYTES - 1);
    build_frame(FAULT_NONE);
    frame_buf[rfc_pkg::FRAME_BYTES] = 8'h00;
    queue_frame(rfc_pkg::FRAME_BYTES + 1);

    // Random traffic under a series of register settings
    for (int phase = 0; phase < 8; phase++) begin
      drain_and_settle();
      case (phase)
        0: apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
        1: apply_setting(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, '1);
        // every version bit ignored
        2: apply_setting(8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom),
                         {$urandom, $urandom});
        // expected version has an ignored bit set, so it never matches
        3: apply_setting(8'h41, 8'h40, 8'h00, 8'h01, 8'h02, 64'h0123_4567_89AB_CDEF);
        default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), {$urandom, $urandom});
      endcase
      rx_mode <= rx_mode_t'($urandom_range(RX_OPEN, RX_SPARSE));
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) phase_bytes += queue_random_frame();
    end

    drain_and_settle();
    $display("Covered %0d bytes in %0d frames under %0d register settings",
             bytes_accepted, frames_queued, settings_used);
    $display("Statuses: ok %0d len %0d start %0d ver %0d end %0d rsp %0d sum %0d id %0d",
             status_seen[rfc_pkg::ST_OK], status_seen[rfc_pkg::ST_LENGTH],
             status_seen[rfc_pkg::ST_START], status_seen[rfc_pkg::ST_VERSION],
             status_seen[rfc_pkg::ST_END], status_seen[rfc_pkg::ST_RESPONSE],
             status_seen[rfc_pkg::ST_CHECKSUM], status_seen[rfc_pkg::ST_ID]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Byte driver: bursts of random length with random gaps; holds data while
  // the DUT back-pressures.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        next_item = byte_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_item.data;
        in_tlast  <= next_item.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Status receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick++;
      case (rx_mode)
        RX_OPEN:     out_tready <= 1'b1;
        RX_CHOPPY:   out_tready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_tready <= ((rx_tick % 11) < 4);
        default:     out_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks status transactions, then feeds accepted bytes to the
  // predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    status_exp_t exp_st;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        status_seen[out_tdata[2:0]]++;
        if (status_due.size() == 0) begin
          $error("status transaction with none expected: out_tdata=%h", out_tdata);
          fail_count++;
        end else begin
          exp_st = status_due.pop_front();
          if (out_tdata[2:0] !== exp_st.status) begin
            $error("status: expected %0d actual %0d", exp_st.status, out_tdata[2:0]);
            fail_count++;
          end
          if (out_tdata[10:3] !== exp_st.rsp) begin
            $error("response_value: expected %h actual %h", exp_st.rsp, out_tdata[10:3]);
            fail_count++;
          end
          if (out_tdata[15:11] !== 5'h00) begin
            $error("tdata pad: expected 00 actual %h", out_tdata[15:11]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        judge_frame_byte(in_tdata, in_tlast);
        bytes_accepted++;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: %0d statuses outstanding", status_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
